[design/rgd_pkg.sv]
package rgd_pkg;

  localparam int SCREEN_ROWS   = 512;
  localparam int TEXTURE_WIDTH = 64;
  localparam int MAP_CELLS     = 4096;

  localparam int ADDR_W  = $clog2(MAP_CELLS);
  localparam int TEX_W   = $clog2(TEXTURE_WIDTH);
  localparam int WALK_CAP = 256;
  localparam int STEP_W  = $clog2(WALK_CAP) + 1;
  localparam int DIV_NUM_W = 40;

  localparam logic [7:0]  WALL_LIMIT = 8'd21;
  localparam logic [23:0] DIST_MAX   = 24'hFFFFFF;
  localparam logic [15:0] LH_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    CFG_MAP_WIDTH   = 2'd0,
    CFG_MAP_HEIGHT  = 2'd1,
    CFG_VIEW_CENTER = 2'd2,
    CFG_VIEW_OFFSET = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_STEP, ST_ADDR, ST_CHECK,
    ST_DIST_GO, ST_DIST_WAIT, ST_LH_GO, ST_LH_WAIT, ST_MUL, ST_DONE, ST_MISS
  } state_t;

  typedef struct packed {
    logic clr;
    logic wr;
    logic load;
    logic step;
    logic rd;
    logic latch_cell;
    logic dist_go;
    logic dist_take;
    logic lh_go;
    logic lh_take;
    logic mul;
    logic out_load;
    logic out_miss;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_out;
    logic bound_out;
    logic wall;
    logic cap_reached;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[design/rgd_div.sv]
module rgd_div
  import rgd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] numer,
  input  logic [23:0]          denom,
  output logic                 done,
  output logic [23:0]          quot
);

  logic                 busy;
  logic [5:0]           cnt;
  logic [DIV_NUM_W-1:0] num;
  logic [23:0]          den;
  logic [23:0]          rem;
  logic [24:0]          trial;
  logic                 ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem, num[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= numer;
      den  <= denom;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? 24'(trial - {1'b0, den}) : trial[23:0];
      num  <= {num[DIV_NUM_W-2:0], 1'b0};
      quot <= {quot[22:0], ge};
    end
  end

endmodule

[design/rgd_datapath.sv]
module rgd_datapath
  import rgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic [11:0]        cell_index,
  input  logic [7:0]         cell_value,
  input  logic [21:0]        pos_x,
  input  logic [21:0]        pos_y,
  input  logic signed [18:0] ray_dir_x,
  input  logic signed [18:0] ray_dir_y,
  input  logic [23:0]        side_dist_x,
  input  logic [23:0]        side_dist_y,
  input  logic [23:0]        delta_dist_x,
  input  logic [23:0]        delta_dist_y,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [23:0]        wall_distance,
  output logic [15:0]        slice_height,
  output logic [8:0]         draw_top,
  output logic signed [10:0] draw_bottom,
  output logic [4:0]         texture_index,
  output logic [5:0]         texture_column,
  output logic               hit_side,
  output logic               missed
);

  // configuration
  logic [6:0]         map_width, map_height;
  logic [9:0]         view_center;
  logic signed [10:0] view_offset;
  logic [6:0]         w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= 7'd64;
      map_height  <= 7'd64;
      view_center <= 10'd256;
      view_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MAP_WIDTH:   map_width   <= cfg_data[6:0];
        CFG_MAP_HEIGHT:  map_height  <= cfg_data[6:0];
        CFG_VIEW_CENTER: view_center <= cfg_data[9:0];
        CFG_VIEW_OFFSET: view_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (map_width  > 7'd64) ? 7'd64 : map_width;
  assign h_eff = (map_height > 7'd64) ? 7'd64 : map_height;

  // map store
  logic [7:0]        mem [MAP_CELLS];
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[cell_index[ADDR_W-1:0]] <= cell_value;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // walk registers
  logic [21:0]        px, py;
  logic signed [18:0] rx, ry;
  logic [23:0]        ddx, ddy;
  logic [31:0]        dx, dy;
  logic signed [7:0]  cx, cy;
  logic               side;
  logic [STEP_W-1:0]  steps;
  logic [7:0]         hit_code;
  logic [32:0]        sum_x, sum_y;
  logic [12:0]        prod_addr;

  assign sum_x = {1'b0, dx} + {9'b0, ddx};
  assign sum_y = {1'b0, dy} + {9'b0, ddy};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px    <= pos_x;
      py    <= pos_y;
      rx    <= ray_dir_x;
      ry    <= ray_dir_y;
      ddx   <= delta_dist_x;
      ddy   <= delta_dist_y;
      dx    <= {8'b0, side_dist_x};
      dy    <= {8'b0, side_dist_y};
      cx    <= {2'b0, pos_x[21:16]};
      cy    <= {2'b0, pos_y[21:16]};
      side  <= 1'b0;
      steps <= '0;
    end else if (cmd.step) begin
      steps <= steps + 1'b1;
      if (dx < dy) begin
        dx   <= sum_x[32] ? 32'hFFFFFFFF : sum_x[31:0];
        cx   <= rx[18] ? cx - 8'sd1 : cx + 8'sd1;
        side <= 1'b0;
      end else begin
        dy   <= sum_y[32] ? 32'hFFFFFFFF : sum_y[31:0];
        cy   <= ry[18] ? cy - 8'sd1 : cy + 8'sd1;
        side <= 1'b1;
      end
    end
    if (cmd.latch_cell) begin
      hit_code <= rd_data;
    end
  end

  assign prod_addr = cy[5:0] * w_eff;
  assign rd_addr   = ADDR_W'(prod_addr + {7'b0, cx[5:0]});

  assign sts.clr_last    = (clr_addr == ADDR_W'(MAP_CELLS - 1));
  assign sts.start_out   = ({1'b0, cx[5:0]} >= w_eff) || ({1'b0, cy[5:0]} >= h_eff);
  assign sts.bound_out   = cx[7] || cy[7] || (cx[6:0] >= w_eff) || (cy[6:0] >= h_eff);
  assign sts.wall        = (rd_data != 8'd0) && (rd_data < WALL_LIMIT);
  assign sts.cap_reached = (steps == STEP_W'(WALK_CAP));
  assign sts.out_free    = !out_valid || out_ready;

  // distance: (cell edge - position) / direction, on the side that was hit
  logic signed [7:0]  c_sel;
  logic [21:0]        p_sel;
  logic signed [18:0] r_sel;
  logic signed [23:0] num;
  logic [23:0]        num_neg;
  logic [22:0]        n_mag;
  logic [18:0]        d_mag;
  logic               sp_case;
  logic [23:0]        sp_val;
  logic [23:0]        perp;
  logic [15:0]        lh;

  assign c_sel = side ? cy : cx;
  assign p_sel = side ? py : px;
  assign r_sel = side ? ry : rx;

  assign num = $signed({c_sel, 16'b0}) - $signed({2'b0, p_sel})
             + (r_sel[18] ? 24'sd65536 : 24'sd0);
  assign num_neg = -num;
  assign n_mag = num[23] ? num_neg[22:0] : num[22:0];
  assign d_mag = r_sel[18] ? 19'(-r_sel) : r_sel;

  always_comb begin
    sp_case = 1'b1;
    sp_val  = '0;
    if (r_sel == '0) begin
      sp_val = DIST_MAX;
    end else if (num == '0 || (num[23] != r_sel[18])) begin
      sp_val = '0;
    end else if ({4'b0, n_mag} >= {d_mag, 8'b0}) begin
      sp_val = DIST_MAX;
    end else begin
      sp_case = 1'b0;
    end
  end

  // shared divider
  logic [DIV_NUM_W-1:0] div_numer;
  logic [23:0]          div_denom;
  logic                 div_done;
  logic [23:0]          div_quot;

  assign div_numer = cmd.lh_go ? DIV_NUM_W'(SCREEN_ROWS) << 16
                               : {1'b0, n_mag, 16'b0};
  assign div_denom = cmd.lh_go ? perp : {5'b0, d_mag};

  rgd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.dist_go || cmd.lh_go),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign sts.div_done = div_done;

  logic [31:0] mag;
  logic signed [18:0] r_oth;
  logic [21:0]        p_oth;
  logic [18:0]        r_oth_mag;
  logic [42:0]        mul_full;

  assign r_oth     = side ? rx : ry;
  assign p_oth     = side ? px : py;
  assign r_oth_mag = r_oth[18] ? 19'(-r_oth) : r_oth;
  assign mul_full  = perp * r_oth_mag;

  always_ff @(posedge clk) begin
    if (cmd.dist_take) begin
      perp <= sp_case ? sp_val : div_quot;
    end
    if (cmd.lh_take) begin
      lh <= (perp <= 24'(SCREEN_ROWS)) ? LH_MAX : div_quot[15:0];
    end
    if (cmd.mul) begin
      mag <= mul_full[31:0];
    end
  end

  // draw limits and texture column
  logic [31:0]        prod32;
  logic [15:0]        frac;
  logic [TEX_W-1:0]   col;
  logic               flip;
  logic signed [17:0] top_raw, bot_raw;
  logic [8:0]         top_clip;
  logic signed [10:0] bot_clip;

  assign prod32 = r_oth[18] ? 32'(-mag) : mag;
  assign frac   = p_oth[15:0] + prod32[31:16];
  assign flip   = side ? ry[18] : (!rx[18] && rx != '0);
  assign col    = flip ? ~frac[15 -: TEX_W] : frac[15 -: TEX_W];

  assign top_raw = $signed({8'b0, view_center}) - $signed({3'b0, lh[15:1]})
                 + $signed({{7{view_offset[10]}}, view_offset});
  assign bot_raw = $signed({8'b0, view_center}) + $signed({3'b0, lh[15:1]})
                 + $signed({{7{view_offset[10]}}, view_offset});

  always_comb begin
    if (top_raw < 18'sd0) begin
      top_clip = '0;
    end else if (top_raw > 18'(SCREEN_ROWS - 1)) begin
      top_clip = 9'(SCREEN_ROWS - 1);
    end else begin
      top_clip = top_raw[8:0];
    end
    if (bot_raw > 18'(SCREEN_ROWS - 1)) begin
      bot_clip = 11'(SCREEN_ROWS - 1);
    end else begin
      bot_clip = bot_raw[10:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_miss) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      wall_distance  <= perp;
      slice_height   <= lh;
      draw_top       <= top_clip;
      draw_bottom    <= bot_clip;
      texture_index  <= 5'(hit_code - 8'd1);
      texture_column <= 6'(col);
      hit_side       <= side;
      missed         <= 1'b0;
    end else if (cmd.out_miss) begin
      wall_distance  <= '0;
      slice_height   <= '0;
      draw_top       <= '0;
      draw_bottom    <= '0;
      texture_index  <= '0;
      texture_column <= '0;
      hit_side       <= 1'b0;
      missed         <= 1'b1;
    end
  end

endmodule

[design/rgd_ctrl.sv]
module rgd_ctrl
  import rgd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    kind,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind) begin
            cmd.load   = 1'b1;
            state_next = ST_START;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_START: begin
        state_next = sts.start_out ? ST_MISS : ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        if (sts.bound_out) begin
          state_next = ST_MISS;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.latch_cell = 1'b1;
        if (sts.wall) state_next = ST_DIST_GO;
        else if (sts.cap_reached) state_next = ST_MISS;
        else state_next = ST_STEP;
      end
      ST_DIST_GO: begin
        cmd.dist_go = 1'b1;
        state_next  = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: begin
        if (sts.div_done) begin
          cmd.dist_take = 1'b1;
          state_next    = ST_LH_GO;
        end
      end
      ST_LH_GO: begin
        cmd.lh_go  = 1'b1;
        state_next = ST_LH_WAIT;
      end
      ST_LH_WAIT: begin
        if (sts.div_done) begin
          cmd.lh_take = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (sts.out_free) begin
          cmd.out_miss = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[design/ray_grid_dda_wall_hit_unit.sv]
// Sequence: a map write is taken in the idle state. A ray takes a start state, then per grid
//   step a step, an address and a check state (up to 256 steps); on a wall hit, two divisions,
//   a multiply and an output state follow, the last waiting while a result is still held.
// Throughput: one item at a time; writes every cycle while idle, rays as above.
// Reset: synchronous; a clearing pass then zeroes all 4096 map cells, one a cycle, before
//   the first item is taken. Registers return to 64, 64, 256, 0.
module ray_grid_dda_wall_hit_unit
  import rgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  // item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [11:0]        cell_index,
  input  logic [7:0]         cell_value,
  input  logic [21:0]        pos_x,
  input  logic [21:0]        pos_y,
  input  logic signed [18:0] ray_dir_x,
  input  logic signed [18:0] ray_dir_y,
  input  logic [23:0]        side_dist_x,
  input  logic [23:0]        side_dist_y,
  input  logic [23:0]        delta_dist_x,
  input  logic [23:0]        delta_dist_y,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        wall_distance,
  output logic [15:0]        slice_height,
  output logic [8:0]         draw_top,
  output logic signed [10:0] draw_bottom,
  output logic [4:0]         texture_index,
  output logic [5:0]         texture_column,
  output logic               hit_side,
  output logic               missed
);

  cmd_t    cmd;
  status_t sts;

  // Sequencer: clears the map, takes items, walks cells and orders the divisions.
  // The result register holds a finished transfer while the next item is walked.
  rgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Map store, DDA walk registers, shared divider and result register.
  rgd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cell_index     (cell_index),
    .cell_value     (cell_value),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .ray_dir_x      (ray_dir_x),
    .ray_dir_y      (ray_dir_y),
    .side_dist_x    (side_dist_x),
    .side_dist_y    (side_dist_y),
    .delta_dist_x   (delta_dist_x),
    .delta_dist_y   (delta_dist_y),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .wall_distance  (wall_distance),
    .slice_height   (slice_height),
    .draw_top       (draw_top),
    .draw_bottom    (draw_bottom),
    .texture_index  (texture_index),
    .texture_column (texture_column),
    .hit_side       (hit_side),
    .missed         (missed)
  );

endmodule
